// ----- sv/ffha_pkg.sv -----
// Package for the first-fit heap allocator: header constants, status codes
// and the sequencer state type. No dependencies.
`default_nettype none
package ffha_pkg;

   localparam int unsigned HEAP_BYTES_DEF      = 65536;
   localparam int unsigned MIN_SPLIT_BYTES_DEF = 16;
   localparam int unsigned HDR_BYTES           = 12;

   localparam logic [31:0] FREE_MARK  = 32'hF4EE_F4EE;
   localparam logic [31:0] MAGIC_USED = 32'hA110_CA7E;

   // header word positions
   localparam logic [1:0] W_SIZE  = 2'd0;
   localparam logic [1:0] W_MAGIC = 2'd1;
   localparam logic [1:0] W_NEXT  = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] STAT_ALLOC_OK   = 2'd0;
   localparam logic [1:0] STAT_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] STAT_FREED      = 2'd2;
   localparam logic [1:0] STAT_FREE_IGN   = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_START,
      ST_A_CHK,
      ST_A_RSZ,
      ST_A_RMG,
      ST_A_RNX,
      ST_A_S0,
      ST_A_S1,
      ST_A_S2,
      ST_A_LNK,
      ST_A_B0,
      ST_A_B2,
      ST_A_B1,
      ST_F_START,
      ST_F_RMG,
      ST_F_RSZ,
      ST_F_W2,
      ST_F_WALK,
      ST_F_WNX,
      ST_F_M1,
      ST_F_M2,
      ST_F_M3,
      ST_F_M4,
      ST_F_P1,
      ST_F_P2,
      ST_F_P3,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- sv/first_fit_heap_allocator.sv -----
// After reset a clearing pass writes every header word, during which no item is taken.
// An allocate walks the free list reading each block's header, then on a split writes the
// remainder's header, links the list and writes the block's header; a free checks and marks
// the block, walks the list to its place and merges with touching neighbours; then the
// result register is loaded. One item at a time; the single-port header memory sets this.
// Reset (synchronous, active high) clears control state, heap base, list head and count.
`default_nettype none
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int unsigned HEAP_BYTES      = HEAP_BYTES_DEF,
   parameter int unsigned MIN_SPLIT_BYTES = MIN_SPLIT_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [31:0] req_request_size,
   input  wire logic [31:0] req_block_pointer,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_payload_address,
   output logic [1:0]       rsp_status,
   output logic [16:0]      rsp_used_bytes,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_heap_base
);

   localparam int unsigned WORDS      = HEAP_BYTES / 4;
   localparam int unsigned AW         = $clog2(WORDS);
   localparam int unsigned OFF_W      = $clog2(HEAP_BYTES + 1);
   localparam int unsigned WALK_LIMIT = HEAP_BYTES / HDR_BYTES + 1;
   localparam int unsigned SW         = $clog2(WALK_LIMIT + 1);
   localparam logic [OFF_W-1:0] NONE  = OFF_W'(HEAP_BYTES);
   localparam logic [31:0] HDR32      = 32'(HDR_BYTES);
   localparam logic [31:0] MAXREQ     = 32'(HEAP_BYTES - HDR_BYTES);

   // header fits in the window at a word-aligned offset
   function automatic logic hdr_ok(input logic [31:0] off);
      hdr_ok = (off[1:0] == 2'b00) && (off <= MAXREQ);
   endfunction

   function automatic logic [31:0] widx(input logic [31:0] off, input logic [1:0] k);
      widx = (off >> 2) + 32'(k);
   endfunction

   // header memory: one port, registered read
   logic [31:0] mem [WORDS];
   logic [31:0] rdata_ff;
   logic        mem_we, mem_re;
   logic [31:0] mem_idx, mem_wd;
   logic        idx_ok;

   assign idx_ok = mem_idx < 32'(WORDS);

   always_ff @(posedge clock) begin
      if (mem_we && idx_ok) begin
         mem[mem_idx[AW-1:0]] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_idx[AW-1:0]];
      end
   end

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [OFF_W-1:0] head_ff, head_in;
   logic [OFF_W-1:0] count_ff, count_in;
   logic [31:0]      base_ff, base_in;
   logic             act_ff, act_in;
   logic [31:0]      req_ff, req_in;       // size, or pointer on a free
   logic [OFF_W-1:0] b_ff, b_in;
   logic [OFF_W-1:0] prev_ff, prev_in;
   logic [OFF_W-1:0] cur_ff, cur_in;
   logic [OFF_W-1:0] nxt_ff, nxt_in;
   logic [31:0]      sz_ff, sz_in;
   logic [SW-1:0]    steps_ff, steps_in;
   logic             fit_ff, fit_in;
   logic             split_ff, split_in;
   logic [31:0]      addr_ff, addr_in;
   logic [1:0]       stat_ff, stat_in;
   logic             rv_ff, rv_in;
   logic [31:0]      ra_ff, ra_in;
   logic [1:0]       rs_ff, rs_in;
   logic [16:0]      ru_ff, ru_in;

   logic [31:0] rest_off, fp, fb, cnt32, b32, prev32, cur32;
   logic [OFF_W-1:0] tgt;

   assign b32      = 32'(b_ff);
   assign prev32   = 32'(prev_ff);
   assign cur32    = 32'(cur_ff);
   assign rest_off = b32 + HDR32 + req_ff;
   assign fp       = req_ff - base_ff;
   assign fb       = fp - HDR32;
   assign cnt32    = 32'(count_ff);
   assign tgt      = split_ff ? rest_off[OFF_W-1:0] : nxt_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid           = rv_ff;
   assign rsp_payload_address = ra_ff;
   assign rsp_status          = rs_ff;
   assign rsp_used_bytes      = ru_ff;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      head_in  = head_ff;
      count_in = count_ff;
      base_in  = base_ff;
      act_in   = act_ff;
      req_in   = req_ff;
      b_in     = b_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      sz_in    = sz_ff;
      steps_in = steps_ff;
      fit_in   = fit_ff;
      split_in = split_ff;
      addr_in  = addr_ff;
      stat_in  = stat_ff;
      rv_in    = rv_ff;
      ra_in    = ra_ff;
      rs_in    = rs_ff;
      ru_in    = ru_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_idx  = 32'd0;
      mem_wd   = 32'd0;

      if (csr_valid && csr_ready) begin
         base_in = csr_heap_base;
      end
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // initial heap: one free block over the whole window
            mem_we  = 1'b1;
            mem_idx = 32'(clr_ff);
            if (clr_ff == AW'(W_SIZE)) begin
               mem_wd = MAXREQ;
            end else if (clr_ff == AW'(W_MAGIC)) begin
               mem_wd = FREE_MARK;
            end else if (clr_ff == AW'(W_NEXT)) begin
               mem_wd = 32'(NONE);
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               req_in   = (req_action == ACT_FREE) ? req_block_pointer : req_request_size;
               addr_in  = 32'd0;
               state_in = (req_action == ACT_FREE) ? ST_F_START : ST_A_START;
            end
         end
         // ---------------- allocate ----------------
         ST_A_START: begin
            if (req_ff == 32'd0 || req_ff > MAXREQ) begin
               stat_in  = STAT_ALLOC_FAIL;
               state_in = ST_DONE;
            end else begin
               req_in   = (req_ff + 32'd3) & ~32'd3;
               b_in     = hdr_ok(32'(head_ff)) ? head_ff : NONE;
               prev_in  = NONE;
               steps_in = '0;
               state_in = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if (b_ff == NONE || 32'(steps_ff) >= 32'(WALK_LIMIT)) begin
               stat_in  = STAT_ALLOC_FAIL;
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               mem_idx  = widx(b32, W_SIZE);
               state_in = ST_A_RSZ;
            end
         end
         ST_A_RSZ: begin
            sz_in    = rdata_ff;
            mem_re   = 1'b1;
            mem_idx  = widx(b32, W_MAGIC);
            state_in = ST_A_RMG;
         end
         ST_A_RMG: begin
            fit_in   = (rdata_ff == FREE_MARK) && (sz_ff >= req_ff);
            mem_re   = 1'b1;
            mem_idx  = widx(b32, W_NEXT);
            state_in = ST_A_RNX;
         end
         ST_A_RNX: begin
            nxt_in = rdata_ff[OFF_W-1:0];
            if (fit_ff) begin
               split_in = {2'b00, sz_ff} >=
                          34'(req_ff) + 34'(HDR_BYTES) + 34'(MIN_SPLIT_BYTES);
               state_in = split_in ? ST_A_S0 : ST_A_LNK;
            end else begin
               prev_in  = b_ff;
               b_in     = hdr_ok(rdata_ff) ? rdata_ff[OFF_W-1:0] : NONE;
               steps_in = steps_ff + SW'(1);
               state_in = ST_A_CHK;
            end
         end
         ST_A_S0: begin
            mem_we   = 1'b1;
            mem_idx  = widx(rest_off, W_SIZE);
            mem_wd   = sz_ff - req_ff - HDR32;
            state_in = ST_A_S1;
         end
         ST_A_S1: begin
            mem_we   = 1'b1;
            mem_idx  = widx(rest_off, W_MAGIC);
            mem_wd   = FREE_MARK;
            state_in = ST_A_S2;
         end
         ST_A_S2: begin
            mem_we   = 1'b1;
            mem_idx  = widx(rest_off, W_NEXT);
            mem_wd   = 32'(nxt_ff);
            state_in = ST_A_LNK;
         end
         ST_A_LNK: begin
            if (prev_ff == NONE) begin
               head_in = tgt;
            end else begin
               mem_we  = 1'b1;
               mem_idx = widx(prev32, W_NEXT);
               mem_wd  = 32'(tgt);
            end
            state_in = split_ff ? ST_A_B0 : ST_A_B2;
         end
         ST_A_B0: begin
            mem_we   = 1'b1;
            mem_idx  = widx(b32, W_SIZE);
            mem_wd   = req_ff;
            state_in = ST_A_B2;
         end
         ST_A_B2: begin
            mem_we   = 1'b1;
            mem_idx  = widx(b32, W_NEXT);
            mem_wd   = 32'(NONE);
            state_in = ST_A_B1;
         end
         ST_A_B1: begin
            mem_we   = 1'b1;
            mem_idx  = widx(b32, W_MAGIC);
            mem_wd   = MAGIC_USED;
            count_in = count_ff + (split_ff ? req_ff[OFF_W-1:0] : sz_ff[OFF_W-1:0]);
            addr_in  = base_ff + b32 + HDR32;
            stat_in  = STAT_ALLOC_OK;
            state_in = ST_DONE;
         end
         // ---------------- free ----------------
         ST_F_START: begin
            if (req_ff == 32'd0 || fp < HDR32 || !hdr_ok(fb)) begin
               stat_in  = STAT_FREE_IGN;
               state_in = ST_DONE;
            end else begin
               b_in     = fb[OFF_W-1:0];
               mem_re   = 1'b1;
               mem_idx  = widx(fb, W_MAGIC);
               state_in = ST_F_RMG;
            end
         end
         ST_F_RMG: begin
            if (rdata_ff != MAGIC_USED) begin
               stat_in  = STAT_FREE_IGN;
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               mem_idx  = widx(b32, W_SIZE);
               state_in = ST_F_RSZ;
            end
         end
         ST_F_RSZ: begin
            sz_in = rdata_ff;
            if (34'(b_ff) + 34'(HDR_BYTES) + 34'(rdata_ff) > 34'(HEAP_BYTES)) begin
               stat_in  = STAT_FREE_IGN;
               state_in = ST_DONE;
            end else begin
               count_in = (rdata_ff > cnt32) ? '0 : count_ff - rdata_ff[OFF_W-1:0];
               mem_we   = 1'b1;
               mem_idx  = widx(b32, W_MAGIC);
               mem_wd   = FREE_MARK;
               state_in = ST_F_W2;
            end
         end
         ST_F_W2: begin
            mem_we   = 1'b1;
            mem_idx  = widx(b32, W_NEXT);
            mem_wd   = 32'(NONE);
            cur_in   = hdr_ok(32'(head_ff)) ? head_ff : NONE;
            prev_in  = NONE;
            steps_in = '0;
            state_in = ST_F_WALK;
         end
         ST_F_WALK: begin
            if (cur_ff != NONE && cur_ff < b_ff && 32'(steps_ff) < 32'(WALK_LIMIT)) begin
               mem_re   = 1'b1;
               mem_idx  = widx(cur32, W_NEXT);
               state_in = ST_F_WNX;
            end else begin
               state_in = ST_F_M1;
            end
         end
         ST_F_WNX: begin
            prev_in  = cur_ff;
            cur_in   = hdr_ok(rdata_ff) ? rdata_ff[OFF_W-1:0] : NONE;
            steps_in = steps_ff + SW'(1);
            state_in = ST_F_WALK;
         end
         ST_F_M1: begin
            // merge with the following free block when they touch
            if (cur_ff != NONE && b32 + HDR32 + sz_ff == cur32) begin
               mem_re   = 1'b1;
               mem_idx  = widx(cur32, W_SIZE);
               state_in = ST_F_M2;
            end else begin
               mem_we   = 1'b1;
               mem_idx  = widx(b32, W_NEXT);
               mem_wd   = cur32;
               nxt_in   = cur_ff;
               state_in = ST_F_P1;
            end
         end
         ST_F_M2: begin
            sz_in    = sz_ff + HDR32 + rdata_ff;
            mem_re   = 1'b1;
            mem_idx  = widx(cur32, W_NEXT);
            state_in = ST_F_M3;
         end
         ST_F_M3: begin
            nxt_in   = rdata_ff[OFF_W-1:0];
            mem_we   = 1'b1;
            mem_idx  = widx(b32, W_SIZE);
            mem_wd   = sz_ff;
            state_in = ST_F_M4;
         end
         ST_F_M4: begin
            mem_we   = 1'b1;
            mem_idx  = widx(b32, W_NEXT);
            mem_wd   = 32'(nxt_ff);
            state_in = ST_F_P1;
         end
         ST_F_P1: begin
            if (prev_ff != NONE) begin
               mem_re   = 1'b1;
               mem_idx  = widx(prev32, W_SIZE);
               state_in = ST_F_P2;
            end else begin
               head_in  = b_ff;
               stat_in  = STAT_FREED;
               state_in = ST_DONE;
            end
         end
         ST_F_P2: begin
            // merge into the preceding free block when they touch
            mem_we = 1'b1;
            if (34'(prev_ff) + 34'(HDR_BYTES) + 34'(rdata_ff) == 34'(b_ff)) begin
               mem_idx  = widx(prev32, W_SIZE);
               mem_wd   = rdata_ff + HDR32 + sz_ff;
               state_in = ST_F_P3;
            end else begin
               mem_idx  = widx(prev32, W_NEXT);
               mem_wd   = b32;
               stat_in  = STAT_FREED;
               state_in = ST_DONE;
            end
         end
         ST_F_P3: begin
            mem_we   = 1'b1;
            mem_idx  = widx(prev32, W_NEXT);
            mem_wd   = 32'(nxt_ff);
            stat_in  = STAT_FREED;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ra_in    = addr_ff;
               rs_in    = stat_ff;
               ru_in    = cnt32[16:0];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         base_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         base_ff  <= base_in;
         rv_ff    <= rv_in;
      end
      act_ff   <= act_in;
      req_ff   <= req_in;
      b_ff     <= b_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      nxt_ff   <= nxt_in;
      sz_ff    <= sz_in;
      steps_ff <= steps_in;
      fit_ff   <= fit_in;
      split_ff <= split_in;
      addr_ff  <= addr_in;
      stat_ff  <= stat_in;
      ra_ff    <= ra_in;
      rs_ff    <= rs_in;
      ru_ff    <= ru_in;
   end

endmodule
`default_nettype wire
